// ===== hdl/bdw_pkg.sv =====
// Shared types and constants for the bounded deque window block.
// Holds the command codes and the input and result item structs.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package bdw_pkg;

  localparam int Depth    = 32;
  localparam int AddrW    = $clog2(Depth);
  localparam int CntW     = $clog2(Depth + 1);
  localparam int WordBits = 64;
  localparam int CmdW     = 4;

  localparam logic [CmdW-1:0] CmdPushBack  = 4'd0;
  localparam logic [CmdW-1:0] CmdPushFront = 4'd1;
  localparam logic [CmdW-1:0] CmdPopBack   = 4'd2;
  localparam logic [CmdW-1:0] CmdPopFront  = 4'd3;
  localparam logic [CmdW-1:0] CmdRead      = 4'd4;
  localparam logic [CmdW-1:0] CmdWrite     = 4'd5;
  localparam logic [CmdW-1:0] CmdClear     = 4'd6;
  localparam logic [CmdW-1:0] CmdFirst     = 4'd7;
  localparam logic [CmdW-1:0] CmdLast      = 4'd8;

  localparam logic [CntW-1:0] CapReset = CntW'(Depth);

  typedef struct packed {
    logic [CmdW-1:0]     command;
    logic [WordBits-1:0] value;
    logic [AddrW-1:0]    position;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] data;
    logic                data_valid;
    logic [CntW-1:0]     fill;
  } out_item_t;

endpackage

// ===== hdl/bounded_deque_window.sv =====
// Bounded deque of 64-bit words held in a ring memory with head and fill count.
// Top level of the block; uses the types and command codes of bdw_pkg.
// Assertions at the end can be left out by defining NO_ASSERTIONS.
`timescale 1ns / 1ps

// The block takes one command item per cycle as long as the result side does not
// stall, and returns exactly one registered result item for each accepted command.
// Each command uses the single port of the slot memory at most once, for a write
// or a registered read, and head and fill count are updated at acceptance, so a
// command sees every earlier one. While a result is held back by out_stall_i, no
// new item is taken. The capacity register is written through cfg_we_i and
// cfg_data_i; a write is ignored unless the queue is empty, zero acts as one, and
// values above 32 act as 32. Slots are not cleared at reset.
module bounded_deque_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bdw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bdw_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [bdw_pkg::CntW-1:0] cfg_data_i
);
  import bdw_pkg::*;

  logic [WordBits-1:0] mem [Depth];
  logic [WordBits-1:0] rd_q;

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  capacity_q;
  logic [CntW-1:0]  cap;

  logic             out_valid_q;
  logic             ok_q, ok_d;
  logic             rdsel_q;
  logic [CntW-1:0]  fill_q;

  logic             acc;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [AddrW-1:0] last_addr;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;

  always_comb begin
    if (capacity_q == '0) begin
      cap = CntW'(1);
    end else if (capacity_q > CntW'(Depth)) begin
      cap = CntW'(Depth);
    end else begin
      cap = capacity_q;
    end
  end

  assign last_addr = head_q + AddrW'(count_q - CntW'(1));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = head_q;
    ok_d     = 1'b0;
    case (in_item_i.command)
      CmdPushBack: begin
        if (count_q >= cap) begin
          head_d  = head_q + AddrW'(1);
          count_d = cap - CntW'(1);
        end
        mem_addr = head_d + count_d[AddrW-1:0];
        mem_we   = 1'b1;
        count_d  = count_d + CntW'(1);
        ok_d     = 1'b1;
      end
      CmdPushFront: begin
        head_d   = head_q - AddrW'(1);
        mem_addr = head_d;
        mem_we   = 1'b1;
        count_d  = (count_q < cap) ? count_q + CntW'(1) : cap;
        ok_d     = 1'b1;
      end
      CmdPopBack: begin
        if (count_q != '0) begin
          mem_addr = last_addr;
          mem_re   = 1'b1;
          count_d  = count_q - CntW'(1);
          ok_d     = 1'b1;
        end
      end
      CmdPopFront: begin
        if (count_q != '0) begin
          mem_re  = 1'b1;
          head_d  = head_q + AddrW'(1);
          count_d = count_q - CntW'(1);
          ok_d    = 1'b1;
        end
      end
      CmdRead: begin
        if ({1'b0, in_item_i.position} < count_q) begin
          mem_addr = head_q + in_item_i.position;
          mem_re   = 1'b1;
          ok_d     = 1'b1;
        end
      end
      CmdWrite: begin
        if (({1'b0, in_item_i.position} <= count_q) &&
            ({1'b0, in_item_i.position} < cap)) begin
          mem_addr = head_q + in_item_i.position;
          mem_we   = 1'b1;
          count_d  = {1'b0, in_item_i.position} + CntW'(1);
          ok_d     = 1'b1;
        end
      end
      CmdClear: begin
        head_d  = '0;
        count_d = '0;
        ok_d    = 1'b1;
      end
      CmdFirst: begin
        if (count_q != '0) begin
          mem_re = 1'b1;
          ok_d   = 1'b1;
        end
      end
      CmdLast: begin
        if (count_q != '0) begin
          mem_addr = last_addr;
          mem_re   = 1'b1;
          ok_d     = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (mem_we) begin
        mem[mem_addr] <= in_item_i.value;
      end else if (mem_re) begin
        rd_q <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      capacity_q  <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (cfg_we_i && count_q == '0) begin
        capacity_q <= cfg_data_i;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ok_q    <= ok_d;
      rdsel_q <= ok_d & mem_re;
      fill_q  <= count_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_item_o.data       = rdsel_q ? rd_q : '0;
  assign out_item_o.data_valid = ok_q;
  assign out_item_o.fill       = fill_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count exceeds the ring depth");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_item_i.command == CmdClear |=> count_q == '0 && head_q == '0)
    else $error("clear did not empty the queue");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.data_valid |-> out_item_o.data == '0)
    else $error("failed command returned nonzero data");

  a_fill_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_item_o.fill == count_q)
    else $error("reported fill differs from the stored count");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_deque_window: a directed command table, then random command phases.
// Results are checked against table rows or a deque model with its own ring, head and fill.
// Depends on bdw_pkg and the bounded_deque_window block.

module testbench;
  import bdw_pkg::*;

  localparam logic [CmdW-1:0]     CmdSpareLo = 4'd9;
  localparam logic [CmdW-1:0]     CmdSpareHi = 4'd15;
  localparam logic [WordBits-1:0] AllOnes    = '1;
  localparam int NumPhases  = 12;
  localparam int PhaseItems = 62;
  localparam int NumRows    = 24;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  logic               cfg_we_i;
  logic [CntW-1:0]    cfg_data_i;

  logic [WordBits-1:0] dq_slot [Depth];
  int                  dq_head;
  int                  dq_fill;
  int                  dq_cap;
  out_item_t           pending_q [$];
  int                  mismatch_count;
  bit                  idle_on;

  logic [CntW-1:0] cap_plan [10] = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd33, 6'd32, 6'd5, 6'd3,
                                     6'd31, 6'd16};

  row_t plan [NumRows] = '{
    '{'{CmdPopBack,   64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdPopFront,  64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdRead,      64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdFirst,     64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdLast,      64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdSpareLo,   64'd0, 5'd0},  1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdSpareHi,   AllOnes, 5'd31}, 1'b1, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdPushBack,  AllOnes, 5'd31}, 1'b1, '{64'd0, 1'b1, 6'd1}},
    '{'{CmdPushFront, 64'd0, 5'd0},  1'b1, '{64'd0, 1'b1, 6'd2}},
    '{'{CmdFirst,     64'd0, 5'd0},  1'b1, '{64'd0, 1'b1, 6'd2}},
    '{'{CmdLast,      64'd0, 5'd0},  1'b1, '{AllOnes, 1'b1, 6'd2}},
    '{'{CmdRead,      64'd0, 5'd1},  1'b1, '{AllOnes, 1'b1, 6'd2}},
    '{'{CmdRead,      64'd0, 5'd2},  1'b1, '{64'd0, 1'b0, 6'd2}},
    '{'{CmdWrite,     64'd5, 5'd3},  1'b1, '{64'd0, 1'b0, 6'd2}},
    '{'{CmdWrite,     64'hA5A5_5A5A_0F0F_F0F0, 5'd2}, 1'b1, '{64'd0, 1'b1, 6'd3}},
    '{'{CmdRead,      64'd0, 5'd2},  1'b0, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdWrite,     64'h0123_4567_89AB_CDEF, 5'd0}, 1'b1, '{64'd0, 1'b1, 6'd1}},
    '{'{CmdRead,      64'd0, 5'd31}, 1'b1, '{64'd0, 1'b0, 6'd1}},
    '{'{CmdPushBack,  64'h8000_0000_0000_0001, 5'd0}, 1'b0, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdPopFront,  64'd0, 5'd0},  1'b0, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdPopBack,   64'd0, 5'd0},  1'b0, '{64'd0, 1'b0, 6'd0}},
    '{'{CmdClear,     64'd0, 5'd0},  1'b1, '{64'd0, 1'b1, 6'd0}},
    '{'{CmdWrite,     AllOnes, 5'd0}, 1'b1, '{64'd0, 1'b1, 6'd1}},
    '{'{CmdWrite,     64'd0, 5'd31}, 1'b1, '{64'd0, 1'b0, 6'd1}}
  };

  bounded_deque_window uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int ring_idx(int n);
    return (dq_head + n) % Depth;
  endfunction

  function automatic out_item_t deque_apply(in_item_t it);
    out_item_t r;
    int cap;
    int pos;
    cap = (dq_cap == 0) ? 1 : ((dq_cap > Depth) ? Depth : dq_cap);
    pos = int'(it.position);
    r = '0;
    case (it.command)
      CmdPushBack: begin
        if (dq_fill >= cap) begin
          dq_head = (dq_head + 1) % Depth;
          dq_fill = cap - 1;
        end
        dq_slot[ring_idx(dq_fill)] = it.value;
        dq_fill++;
        r.data_valid = 1'b1;
      end
      CmdPushFront: begin
        dq_head = (dq_head + Depth - 1) % Depth;
        dq_slot[dq_head] = it.value;
        if (dq_fill < cap) dq_fill++;
        else dq_fill = cap;
        r.data_valid = 1'b1;
      end
      CmdPopBack: begin
        if (dq_fill > 0) begin
          r.data = dq_slot[ring_idx(dq_fill - 1)];
          dq_fill--;
          r.data_valid = 1'b1;
        end
      end
      CmdPopFront: begin
        if (dq_fill > 0) begin
          r.data = dq_slot[dq_head];
          dq_head = (dq_head + 1) % Depth;
          dq_fill--;
          r.data_valid = 1'b1;
        end
      end
      CmdRead: begin
        if (pos < dq_fill) begin
          r.data = dq_slot[ring_idx(pos)];
          r.data_valid = 1'b1;
        end
      end
      CmdWrite: begin
        if (pos <= dq_fill && pos < cap) begin
          dq_slot[ring_idx(pos)] = it.value;
          dq_fill = pos + 1;
          r.data_valid = 1'b1;
        end
      end
      CmdClear: begin
        dq_fill = 0;
        dq_head = 0;
        r.data_valid = 1'b1;
      end
      CmdFirst: begin
        if (dq_fill > 0) begin
          r.data = dq_slot[dq_head];
          r.data_valid = 1'b1;
        end
      end
      CmdLast: begin
        if (dq_fill > 0) begin
          r.data = dq_slot[ring_idx(dq_fill - 1)];
          r.data_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.fill = CntW'(dq_fill);
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    int span;
    pick = $urandom_range(99);
    if (pick < 25) it.command = CmdPushBack;
    else if (pick < 45) it.command = CmdPushFront;
    else if (pick < 53) it.command = CmdPopBack;
    else if (pick < 61) it.command = CmdPopFront;
    else if (pick < 72) it.command = CmdRead;
    else if (pick < 84) it.command = CmdWrite;
    else if (pick < 86) it.command = CmdClear;
    else if (pick < 90) it.command = CmdFirst;
    else if (pick < 94) it.command = CmdLast;
    else it.command = CmdW'($urandom_range(CmdSpareHi, CmdSpareLo));
    case ($urandom_range(9))
      0: it.value = '0;
      1: it.value = AllOnes;
      default: it.value = {$urandom, $urandom};
    endcase
    span = (dq_fill > Depth - 1) ? Depth - 1 : dq_fill;
    if (dq_fill == 0 || $urandom_range(3) == 0) it.position = AddrW'($urandom_range(Depth - 1));
    else it.position = AddrW'($urandom_range(span));
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    bit taken;
    out_item_t r;
    while (idle_on && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!in_stall_o) begin
        taken = 1'b1;
        r = deque_apply(it);
        pending_q.push_back(typed ? want : r);
      end
      @(negedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CntW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    if (dq_fill == 0) dq_cap = int'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 26);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual data=%h valid=%b fill=%0d",
                 $time, out_item_o.data, out_item_o.data_valid, out_item_o.fill);
        mismatch_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_item_o.data !== want.data) begin
          $display("%0t: data expected %h actual %h", $time, want.data, out_item_o.data);
          mismatch_count++;
        end
        if (out_item_o.data_valid !== want.data_valid) begin
          $display("%0t: data_valid expected %b actual %b", $time, want.data_valid,
                   out_item_o.data_valid);
          mismatch_count++;
        end
        if (out_item_o.fill !== want.fill) begin
          $display("%0t: fill expected %0d actual %0d", $time, want.fill, out_item_o.fill);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    in_item_t clear_item;
    int phase;
    int wait_cycles;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    dq_head        = 0;
    dq_fill        = 0;
    dq_cap         = Depth;
    foreach (dq_slot[i]) dq_slot[i] = '0;
    clear_item = '{CmdClear, 64'd0, 5'd0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

    // Every fourth phase keeps its contents, so the capacity write is ignored unless the queue is empty.
    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase % 4 != 3) send_item(clear_item, 1'b0, '0);
      settle();
      write_capacity(phase < 10 ? cap_plan[phase] : CntW'($urandom_range(1, Depth - 1)));
      idle_on = (phase != 6);
      repeat (PhaseItems) send_item(random_item(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 1000 && pending_q.size() != 0; wait_cycles++) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    if (pending_q.size() != 0) begin
      $display("%0t: %0d result items never arrived", $time, pending_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bdw_pkg.sv
hdl/bounded_deque_window.sv
dv/testbench.sv
